### sv/bfaq_pkg.sv
// bfaq_pkg: shared types, constants and helpers for the bloom filter block.
// No dependencies.
package bfaq_pkg;

    localparam int NumBits   = 65536;
    localparam int MaxHashes = 8;
    localparam int IdxW      = 16;
    localparam int LaneW     = 3;

    localparam logic [63:0] FNV_BASIS = 64'd1469598103934665603;
    localparam logic [63:0] FNV_PRIME = 64'd1099511628211;
    localparam logic [63:0] MIX_MUL   = 64'hff51afd7ed558ccd;
    localparam logic [63:0] SEED_MUL  = 64'h9e3779b97f4a7c15;

    localparam logic CFG_BIT_COUNT  = 1'b0;
    localparam logic CFG_HASH_COUNT = 1'b1;

    // item passed from front to back
    typedef struct packed {
        logic       has_byte;
        logic       last;
        logic       func;
        logic [7:0] key_byte;
    } bfaq_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ABS_LO,
        ST_ABS_HI,
        ST_ABS_SUM,
        ST_MIX1,
        ST_MIX2,
        ST_MIX3,
        ST_MOD,
        ST_PROBE,
        ST_PROBE_WAIT,
        ST_DONE
    } bfaq_state_t;

    // start value of lane i
    function automatic logic [63:0] lane_init(input logic [LaneW-1:0] i);
        logic [63:0] s;
        s = SEED_MUL * (64'(i) + 64'd1);
        return FNV_BASIS ^ s;
    endfunction

endpackage

### sv/bloom_filter_add_query_top.sv
// bloom_filter_add_query_top: command port, config registers, front and back.
// Depends on bfaq_pkg, bfaq_front, bfaq_back.
//
// channel   dir  handshake                  payload
// command   in   start & !busy              func, key_byte, has_byte, last
// result    out  result_valid (one cycle)   possibly_present, was_query
// config    in   cfg_we                     cfg_index, cfg_data
//
// A key byte takes a dispatch step, then runs each of the 8 lanes through ABS_LO and ABS_HI
// on one shared 32x32 multiplier, then ABS_SUM. Key end runs per probed lane: lane fetch,
// three multiply passes, the 64-step remainder, probe and check.
// After reset a sweep clears all 65536 bits of the bit store; items queue meanwhile.
// A two-entry queue holds items; busy rises when it is full. Results cannot stall.
module bloom_filter_add_query_top
    import bfaq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        func,
    input  logic [7:0]  key_byte,
    input  logic        has_byte,
    input  logic        last,
    output logic        result_valid,
    output logic        possibly_present,
    output logic        was_query,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [16:0] cfg_data
);

    logic [16:0] bits_reg;
    logic [3:0]  hashes_reg;
    logic        q_valid, q_pop, done;
    bfaq_item_t  q_item;
    logic        pp_c, wq_c;
    logic        rv_reg, pp_reg, wq_reg;

    // clamped config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg   <= 17'(NumBits);
            hashes_reg <= 4'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BIT_COUNT:
                    bits_reg <= (cfg_data < 17'd8) ? 17'd8 :
                                (cfg_data > 17'(NumBits)) ? 17'(NumBits) : cfg_data;
                CFG_HASH_COUNT:
                    hashes_reg <= (cfg_data[3:0] == 4'd0) ? 4'd1 :
                                  (cfg_data[3:0] > 4'(MaxHashes)) ? 4'(MaxHashes) :
                                  cfg_data[3:0];
                default: ;
            endcase
        end
    end

    bfaq_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .func(func),
        .key_byte(key_byte), .has_byte(has_byte), .last(last), .busy(busy),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
    );

    bfaq_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(q_item),
        .q_pop(q_pop), .bits_eff(bits_reg), .hashes_eff(hashes_reg),
        .done(done), .possibly_present(pp_c), .was_query(wq_c)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg <= 1'b0;
            pp_reg <= 1'b0;
            wq_reg <= 1'b0;
        end
        else
        begin
            rv_reg <= done;
            pp_reg <= pp_c;
            wq_reg <= wq_c;
        end
    end

    assign result_valid     = rv_reg;
    assign possibly_present = pp_reg;
    assign was_query        = wq_reg;

    // an add never reports presence
    a_add_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !was_query |-> !possibly_present) else $error("add present");
    // a result needs a queued item
    a_done_pop: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> q_valid && q_pop) else $error("done without item");
    // config stays clamped
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        bits_reg >= 17'd8 && hashes_reg != 4'd0) else $error("config out of range");

endmodule

### sv/bfaq_front.sv
// bfaq_front: accepts items, drops idle ones, queues the rest (depth 2).
// Depends on bfaq_pkg.
module bfaq_front
    import bfaq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       func,
    input  logic [7:0] key_byte,
    input  logic       has_byte,
    input  logic       last,
    output logic       busy,
    output logic       q_valid,
    output bfaq_item_t q_item,
    input  logic       q_pop
);

    bfaq_item_t  slot_reg [2];
    logic        wr_reg, rd_reg;
    logic [1:0]  cnt_reg;
    logic        push;

    assign busy    = (cnt_reg == 2'd2);
    assign push    = start && !busy && (has_byte || last);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = slot_reg[rd_reg];

    // payload slots
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= '{has_byte: has_byte, last: last, func: func,
                                  key_byte: key_byte};
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (q_pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

endmodule

### sv/bfaq_back.sv
// bfaq_back: lane hashing over a shared 32x32 multiplier, mix, modulo and probe.
// Depends on bfaq_pkg.
module bfaq_back
    import bfaq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  bfaq_item_t  q_item,
    output logic        q_pop,
    input  logic [16:0] bits_eff,
    input  logic [3:0]  hashes_eff,
    output logic        done,
    output logic        possibly_present,
    output logic        was_query
);

    bfaq_state_t state_reg, state_next;
    logic [63:0] lane_reg [MaxHashes];
    logic [LaneW-1:0] lane_idx_reg, lane_idx_next;
    logic [63:0] h_reg, h_next;
    logic [63:0] p_lo_reg, p_lo_next, p_hi_reg, p_hi_next;
    logic [16:0] rem_reg, rem_next;
    logic [6:0]  bit_pos_reg, bit_pos_next;
    logic        all_reg, all_next;
    logic        lane_wr, lane_rst;
    logic [63:0] lane_wdata;
    logic        mem_rd_reg;
    logic        mem_we;
    logic [IdxW-1:0] mem_addr;
    logic        filter_mem [NumBits];
    logic        valid_bit_unused;
    logic [31:0] ma, mb;
    logic [63:0] mprod;
    logic [63:0] cur_lane, xb, mul_const;
    logic [17:0] trial;
    logic        clr_reg;
    logic [IdxW:0] clr_cnt_reg;

    assign cur_lane  = lane_reg[lane_idx_reg];
    assign xb        = cur_lane ^ {56'd0, q_item.key_byte};
    assign mul_const = (state_reg == ST_ABS_LO || state_reg == ST_ABS_HI) ?
                       FNV_PRIME : MIX_MUL;
    assign mprod     = 64'(ma) * 64'(mb);
    assign valid_bit_unused = 1'b0;
    assign trial = {rem_reg, h_reg[63]} - {1'b0, bits_eff};

    // operand select for the shared multiplier
    always_comb
    begin
        ma = h_reg[31:0];
        mb = mul_const[31:0];
        case (state_reg)
            ST_ABS_LO: begin ma = xb[31:0];  mb = FNV_PRIME[31:0]; end
            ST_ABS_HI: begin ma = h_reg[63:32]; mb = FNV_PRIME[31:0]; end
            ST_MIX1:   begin ma = h_reg[31:0]; mb = MIX_MUL[31:0]; end
            ST_MIX2:   begin ma = h_reg[63:32]; mb = MIX_MUL[31:0]; end
            ST_MIX3:   begin ma = h_reg[31:0]; mb = MIX_MUL[63:32]; end
            default:   begin ma = h_reg[31:0]; mb = mul_const[31:0]; end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        lane_idx_next = lane_idx_reg;
        h_next        = h_reg;
        p_lo_next     = p_lo_reg;
        p_hi_next     = p_hi_reg;
        rem_next      = rem_reg;
        bit_pos_next  = bit_pos_reg;
        all_next      = all_reg;
        lane_wr       = 1'b0;
        lane_rst      = 1'b0;
        lane_wdata    = '0;
        q_pop         = 1'b0;
        mem_we        = 1'b0;
        mem_addr      = rem_reg[IdxW-1:0];
        done          = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                lane_idx_next = '0;
                all_next      = 1'b1;
                if (q_valid && !clr_reg)
                begin
                    state_next = q_item.has_byte ? ST_ABS_LO : ST_MIX1;
                    if (!q_item.has_byte)
                    begin
                        h_next = lane_reg[0] ^ {33'd0, lane_reg[0][63:33]};
                    end
                end
            end
            // lane * prime: lo*lo, then hi*lo together with lo*hi as a shift (prime hi is 0x100)
            ST_ABS_LO:
            begin
                h_next     = xb;
                p_lo_next  = mprod;
                state_next = ST_ABS_HI;
            end
            ST_ABS_HI:
            begin
                p_hi_next  = {mprod[31:0], 32'd0} + {h_reg[23:0], 40'd0};
                state_next = ST_ABS_SUM;
            end
            ST_ABS_SUM:
            begin
                lane_wr    = 1'b1;
                lane_wdata = p_lo_reg + p_hi_reg;
                if (lane_idx_reg == LaneW'(MaxHashes - 1))
                begin
                    lane_idx_next = '0;
                    if (q_item.last)
                    begin
                        state_next = ST_MOD;
                        bit_pos_next = 7'd127;
                    end
                    else
                    begin
                        q_pop      = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    lane_idx_next = lane_idx_reg + 1'b1;
                    state_next    = ST_ABS_LO;
                end
            end
            ST_MIX1:
            begin
                p_lo_next  = mprod;
                state_next = ST_MIX2;
            end
            ST_MIX2:
            begin
                p_hi_next  = {mprod[31:0], 32'd0};
                state_next = ST_MIX3;
            end
            ST_MIX3:
            begin
                h_next       = p_lo_reg + p_hi_reg + {mprod[31:0], 32'd0};
                h_next       = h_next ^ {33'd0, h_next[63:33]};
                rem_next     = '0;
                bit_pos_next = 7'd64;
                state_next   = ST_PROBE_WAIT;
            end
            // restoring remainder, one bit a cycle
            ST_PROBE_WAIT:
            begin
                if (bit_pos_reg == 7'd0)
                begin
                    state_next = ST_PROBE;
                end
                else
                begin
                    rem_next = trial[17] ? {rem_reg[15:0], h_reg[63]} : trial[16:0];
                    h_next   = {h_reg[62:0], 1'b0};
                    bit_pos_next = bit_pos_reg - 7'd1;
                end
            end
            ST_PROBE:
            begin
                mem_we = !q_item.func;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (q_item.func && !mem_rd_reg)
                begin
                    all_next = 1'b0;
                end
                if (4'(lane_idx_reg) + 4'd1 >= hashes_eff)
                begin
                    lane_rst   = 1'b1;
                    q_pop      = 1'b1;
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    lane_idx_next = lane_idx_reg + 1'b1;
                    state_next    = ST_MOD;
                end
            end
            ST_MOD:
            begin
                h_next = lane_reg[lane_idx_reg] ^ {33'd0, lane_reg[lane_idx_reg][63:33]};
                state_next = ST_MIX1;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign possibly_present = q_item.func && all_next && !valid_bit_unused;
    assign was_query        = q_item.func;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            lane_idx_reg <= '0;
            all_reg      <= 1'b1;
            clr_reg      <= 1'b1;
            clr_cnt_reg  <= '0;
            for (int i = 0; i < MaxHashes; i++)
            begin
                lane_reg[i] <= lane_init(LaneW'(i));
            end
        end
        else
        begin
            state_reg    <= state_next;
            lane_idx_reg <= lane_idx_next;
            all_reg      <= all_next;
            if (clr_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == (IdxW+1)'(NumBits - 1))
                begin
                    clr_reg <= 1'b0;
                end
            end
            if (lane_rst)
            begin
                for (int i = 0; i < MaxHashes; i++)
                begin
                    lane_reg[i] <= lane_init(LaneW'(i));
                end
            end
            else if (lane_wr)
            begin
                lane_reg[lane_idx_reg] <= lane_wdata;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        h_reg       <= h_next;
        p_lo_reg    <= p_lo_next;
        p_hi_reg    <= p_hi_next;
        rem_reg     <= rem_next;
        bit_pos_reg <= bit_pos_next;
    end

    // filter bit store, cleared by a sweep after reset
    always_ff @(posedge clk)
    begin
        if (clr_reg)
        begin
            filter_mem[clr_cnt_reg[IdxW-1:0]] <= 1'b0;
        end
        else if (mem_we)
        begin
            filter_mem[mem_addr] <= 1'b1;
        end
        mem_rd_reg <= filter_mem[mem_addr];
    end

endmodule
